### rtl/lgm_pkg.sv
// ----------------------------------------------------------------------------
// lgm_pkg
// Shared types, codes and helpers for the letter glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package lgm_pkg;

    localparam int MAX_POSITIONS = 32;
    localparam int ALPHABET_SIZE = 26;
    localparam logic [ALPHABET_SIZE-1:0] ALL_LETTERS = 26'h3FFFFFF;

    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_WORD    = 2'd1;
    localparam logic [1:0] CMD_EMPTY_Q = 2'd2;
    localparam logic [1:0] CMD_EMPTY_P = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNTERM_SUB  = 3'd1;
    localparam logic [2:0] ST_BAD_SUB     = 3'd2;
    localparam logic [2:0] ST_UNTERM_RNG  = 3'd3;
    localparam logic [2:0] ST_ILLEGAL     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG    = 3'd5;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_MATCH  = 1'b1;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_byte;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] status_code;
        logic       matched;
    } out_beat_t;

    typedef struct packed {
        logic                     en;
        logic                     star;
        logic [ALPHABET_SIZE-1:0] mask;
    } pos_wr_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } letter_t;

    function automatic letter_t letter_of(input logic [7:0] c);
        letter_t r;
        r.ok  = 1'b0;
        r.idx = 5'd0;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.ok  = 1'b1;
            r.idx = 5'(c - 8'h61);
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.ok  = 1'b1;
            r.idx = 5'(c - 8'h41);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/lgm_cell.sv
// ----------------------------------------------------------------------------
// lgm_cell
// One pattern position: letter mask, star flag and active bit, chained.
// ----------------------------------------------------------------------------
`default_nettype none
module lgm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [LEN_W-1:0]     len,
    input  wire logic [LEN_W-1:0]     len_nx,
    input  wire lgm_pkg::letter_t     letter,
    input  wire lgm_pkg::pos_wr_t     wr,
    input  wire logic [LEN_W-1:0]     wr_idx,
    input  wire logic                 restart,
    input  wire logic                 step,
    input  wire logic                 adv_in,
    input  wire logic                 rip_in,
    input  wire logic                 rs_in,
    output logic                      adv_out,
    output logic                      rip_out,
    output logic                      rs_out,
    output logic                      nxt_bit,
    output logic                      rs_bit
);

    logic [lgm_pkg::ALPHABET_SIZE-1:0] mask_reg;
    logic star_reg;
    logic act_reg;
    logic used;
    logic used_nx;
    logic hit;
    logic star_nx;
    logic wr_here;

    assign used    = len > LEN_W'(IDX);
    assign used_nx = len_nx > LEN_W'(IDX);
    assign hit     = letter.ok && mask_reg[letter.idx];
    assign wr_here = wr.en && (wr_idx == LEN_W'(IDX));
    assign star_nx = wr_here ? wr.star : star_reg;

    assign nxt_bit = (act_reg && star_reg && used) || adv_in || rip_in;
    assign adv_out = act_reg && !star_reg && hit && used;
    assign rip_out = nxt_bit && star_reg && used;
    assign rs_bit  = rs_in;
    assign rs_out  = rs_in && star_nx && used_nx;

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            mask_reg <= wr.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg <= 1'b0;
            act_reg  <= (IDX == 0);
        end
        else
        begin
            if (wr_here)
            begin
                star_reg <= wr.star;
            end
            if (restart)
            begin
                act_reg <= rs_bit;
            end
            else if (step)
            begin
                act_reg <= nxt_bit;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/lgm_parse.sv
// ----------------------------------------------------------------------------
// lgm_parse
// Pattern compiler: bracket parsing, position writes and compile status.
// ----------------------------------------------------------------------------
`default_nettype none
module lgm_parse #(
    parameter int MAX_POS = lgm_pkg::MAX_POSITIONS,
    parameter int LEN_W   = $clog2(MAX_POS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire lgm_pkg::in_beat_t in_data,
    output lgm_pkg::pos_wr_t       wr,
    output logic [LEN_W-1:0]       wr_idx,
    output logic [LEN_W-1:0]       len,
    output logic [LEN_W-1:0]       len_nx,
    output logic                   pat_valid,
    output logic [2:0]             status
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_OUT  = 3'd1;
    localparam logic [2:0] PH_OPEN = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_ITEM = 3'd4;
    localparam logic [2:0] PH_DASH = 3'd5;
    localparam int AW = lgm_pkg::ALPHABET_SIZE;

    logic [2:0]    phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic          valid_reg, valid_next;
    logic [AW-1:0] cm_reg, cm_next;
    logic [4:0]    pend_reg, pend_next;
    logic          inv_reg, inv_next;
    logic [2:0]    err_reg, err_next;

    lgm_pkg::letter_t lt;
    logic [7:0] c;
    logic       full;
    logic       do_item;
    logic [AW-1:0] add_mask;
    logic       add_star;
    logic       add_req;

    assign c  = in_data.char_byte;
    assign lt = lgm_pkg::letter_of(c);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        valid_next = valid_reg;
        cm_next    = cm_reg;
        pend_next  = pend_reg;
        inv_next   = inv_reg;
        err_next   = err_reg;
        add_req    = 1'b0;
        add_mask   = '0;
        add_star   = 1'b0;
        do_item    = 1'b0;
        wr         = '0;
        wr_idx     = len_reg;
        full       = 1'b0;
        if (accept && in_data.command == lgm_pkg::CMD_PATTERN)
        begin
            if (phase_reg == PH_IDLE)
            begin
                len_next   = '0;
                valid_next = 1'b0;
                err_next   = lgm_pkg::ST_OK;
                phase_next = PH_OUT;
            end
            full   = len_next >= LEN_W'(MAX_POS);
            wr_idx = len_next;
            if (err_next == lgm_pkg::ST_OK)
            begin
                unique case (phase_next)
                    PH_OUT:
                    begin
                        if (c == lgm_pkg::CH_STAR)
                        begin
                            add_req  = 1'b1;
                            add_star = 1'b1;
                        end
                        else if (c == lgm_pkg::CH_QUERY)
                        begin
                            add_req  = 1'b1;
                            add_mask = lgm_pkg::ALL_LETTERS;
                        end
                        else if (c == lgm_pkg::CH_OPEN)
                        begin
                            if (full)
                            begin
                                err_next = lgm_pkg::ST_TOO_LONG;
                            end
                            else
                            begin
                                cm_next    = '0;
                                inv_next   = 1'b0;
                                phase_next = PH_OPEN;
                            end
                        end
                        else if (lt.ok)
                        begin
                            add_req  = 1'b1;
                            add_mask = AW'(1) << lt.idx;
                        end
                        else
                        begin
                            err_next = lgm_pkg::ST_ILLEGAL;
                        end
                    end
                    PH_OPEN:
                    begin
                        if (c == lgm_pkg::CH_CARET)
                        begin
                            inv_next   = 1'b1;
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            do_item = 1'b1;
                        end
                    end
                    PH_BODY:
                    begin
                        do_item = 1'b1;
                    end
                    PH_ITEM:
                    begin
                        if (c == lgm_pkg::CH_DASH)
                        begin
                            phase_next = PH_DASH;
                        end
                        else
                        begin
                            cm_next = cm_reg | (AW'(1) << pend_reg);
                            do_item = 1'b1;
                        end
                    end
                    PH_DASH:
                    begin
                        if (!lt.ok)
                        begin
                            err_next = lgm_pkg::ST_UNTERM_SUB;
                        end
                        else if (lt.idx < pend_reg)
                        begin
                            err_next = lgm_pkg::ST_BAD_SUB;
                        end
                        else
                        begin
                            cm_next = cm_reg | ((lgm_pkg::ALL_LETTERS << pend_reg)
                                & (lgm_pkg::ALL_LETTERS >> (5'd25 - lt.idx)));
                            phase_next = PH_BODY;
                        end
                    end
                    default:
                    begin
                        err_next = err_reg;
                    end
                endcase
                if (do_item)
                begin
                    if (c == lgm_pkg::CH_CLOSE)
                    begin
                        add_req  = 1'b1;
                        add_mask = inv_next ? ~cm_next : cm_next;
                        if (!full)
                        begin
                            phase_next = PH_OUT;
                        end
                    end
                    else if (lt.ok)
                    begin
                        pend_next  = lt.idx;
                        phase_next = PH_ITEM;
                    end
                    else
                    begin
                        err_next = lgm_pkg::ST_ILLEGAL;
                    end
                end
                if (add_req)
                begin
                    if (full)
                    begin
                        err_next = lgm_pkg::ST_TOO_LONG;
                    end
                    else
                    begin
                        wr.en    = 1'b1;
                        wr.star  = add_star;
                        wr.mask  = add_mask;
                        len_next = len_next + LEN_W'(1);
                    end
                end
            end
            if (in_data.is_last)
            begin
                if (err_next == lgm_pkg::ST_OK)
                begin
                    if (phase_next == PH_DASH)
                    begin
                        err_next = lgm_pkg::ST_UNTERM_SUB;
                    end
                    else if (phase_next != PH_OUT)
                    begin
                        err_next = lgm_pkg::ST_UNTERM_RNG;
                    end
                end
                valid_next = (err_next == lgm_pkg::ST_OK);
                phase_next = PH_IDLE;
            end
        end
        else if (accept && in_data.command == lgm_pkg::CMD_EMPTY_P)
        begin
            len_next   = '0;
            valid_next = 1'b1;
            phase_next = PH_IDLE;
            err_next   = lgm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            valid_reg <= 1'b1;
            cm_reg    <= '0;
            pend_reg  <= '0;
            inv_reg   <= 1'b0;
            err_reg   <= lgm_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
            cm_reg    <= cm_next;
            pend_reg  <= pend_next;
            inv_reg   <= inv_next;
            err_reg   <= err_next;
        end
    end

    assign len       = len_reg;
    assign len_nx    = len_next;
    assign pat_valid = valid_reg;
    assign status    = err_next;

endmodule
`default_nettype wire

### rtl/letter_glob_matcher.sv
// ----------------------------------------------------------------------------
// letter_glob_matcher
// Glob pattern compiler and streaming word matcher over a row of cells.
// ----------------------------------------------------------------------------
// Takes one beat per cycle: pattern bytes compile into a row of position
// cells, and word bytes advance the active-position set in all cells at
// once. A result beat appears in the cycle after the last byte of a
// pattern or word, or after an empty-word or empty-pattern command. The
// output register holds one result; while it waits unaccepted the input
// stalls, and the next beat enters in the same cycle that the waiting
// result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module letter_glob_matcher #(
    parameter int MAX_POS = lgm_pkg::MAX_POSITIONS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lgm_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lgm_pkg::out_beat_t      out_data
);

    localparam int LEN_W = $clog2(MAX_POS + 1);

    logic accept;
    lgm_pkg::pos_wr_t wr;
    logic [LEN_W-1:0] wr_idx;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_nx;
    logic pat_valid;
    logic [2:0] status;
    lgm_pkg::letter_t letter;
    logic restart;
    logic step;
    logic is_pat, is_word, is_q, is_ep;

    logic [MAX_POS:0] adv_c, rip_c, rs_c;
    logic [MAX_POS:0] nxt_v, rs_v;
    logic act_top_reg;
    logic hit_nxt, hit_rs;

    logic out_valid_reg;
    lgm_pkg::out_beat_t out_data_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_pat   = in_data.command == lgm_pkg::CMD_PATTERN;
    assign is_word  = in_data.command == lgm_pkg::CMD_WORD;
    assign is_q     = in_data.command == lgm_pkg::CMD_EMPTY_Q;
    assign is_ep    = in_data.command == lgm_pkg::CMD_EMPTY_P;
    assign letter   = lgm_pkg::letter_of(in_data.char_byte);
    assign step     = accept && is_word;
    assign restart  = accept && (is_q || is_ep || ((is_pat || is_word) && in_data.is_last));

    lgm_parse #(.MAX_POS(MAX_POS), .LEN_W(LEN_W)) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .wr        (wr),
        .wr_idx    (wr_idx),
        .len       (len),
        .len_nx    (len_nx),
        .pat_valid (pat_valid),
        .status    (status)
    );

    assign adv_c[0] = 1'b0;
    assign rip_c[0] = 1'b0;
    assign rs_c[0]  = 1'b1;

    for (genvar j = 0; j < MAX_POS; j++)
    begin : g_cell
        lgm_cell #(.IDX(j), .LEN_W(LEN_W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .len     (len),
            .len_nx  (len_nx),
            .letter  (letter),
            .wr      (wr),
            .wr_idx  (wr_idx),
            .restart (restart),
            .step    (step),
            .adv_in  (adv_c[j]),
            .rip_in  (rip_c[j]),
            .rs_in   (rs_c[j]),
            .adv_out (adv_c[j+1]),
            .rip_out (rip_c[j+1]),
            .rs_out  (rs_c[j+1]),
            .nxt_bit (nxt_v[j]),
            .rs_bit  (rs_v[j])
        );
    end

    assign nxt_v[MAX_POS] = adv_c[MAX_POS] || rip_c[MAX_POS];
    assign rs_v[MAX_POS]  = rs_c[MAX_POS];

    always_comb
    begin
        hit_nxt = 1'b0;
        hit_rs  = 1'b0;
        for (int j = 0; j <= MAX_POS; j++)
        begin
            if (len == LEN_W'(j))
            begin
                hit_nxt = nxt_v[j];
                hit_rs  = rs_v[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_top_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                act_top_reg <= rs_v[MAX_POS];
            end
            else if (step)
            begin
                act_top_reg <= nxt_v[MAX_POS];
            end
            if (restart)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (restart)
        begin
            out_data_reg.result_kind <= (is_pat || is_ep) ? lgm_pkg::KIND_STATUS
                                                          : lgm_pkg::KIND_MATCH;
            out_data_reg.status_code <= is_pat ? status : lgm_pkg::ST_OK;
            out_data_reg.matched     <= pat_valid && ((is_q && hit_rs) || (is_word && hit_nxt));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

### rtl/lgm_checker.sv
// ----------------------------------------------------------------------------
// lgm_checker
// Port-level checks for the letter glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none
module lgm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire lgm_pkg::in_beat_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lgm_pkg::out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped while stalled");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == lgm_pkg::KIND_STATUS |-> !out_data.matched)
        else $error("status beat carries match");

    a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == lgm_pkg::KIND_MATCH
        |-> out_data.status_code == lgm_pkg::ST_OK)
        else $error("match beat carries status");

    a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command == lgm_pkg::CMD_EMPTY_Q
        |=> out_valid && out_data.result_kind == lgm_pkg::KIND_MATCH)
        else $error("empty word query gave no answer");

endmodule

bind letter_glob_matcher lgm_checker u_lgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
